>>> rtl/gpio_pkg.sv
// ============================================================================
// gpio_pkg: shared types and constants for the GPIO port
// Register indexes, request kinds, interrupt condition codes and the
// structures that pass between the register block and the top level.
// ============================================================================
package gpio_pkg;

    // Number of pins that exist; bits at or above it are dropped.
    localparam int PIN_COUNT = 32;
    localparam int WORD_W    = 32;
    localparam int HALF_PINS = 16;

    localparam logic [WORD_W-1:0] PIN_MASK =
        WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_SAMPLE = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        REG_DATA     = 3'd0,
        REG_DIR      = 3'd1,
        REG_ICR_LOW  = 3'd2,
        REG_ICR_HIGH = 3'd3,
        REG_MASK     = 3'd4,
        REG_STATUS   = 3'd5,
        REG_EDGE_SEL = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ICR_LOW_LEVEL  = 2'd0,
        ICR_HIGH_LEVEL = 2'd1,
        ICR_RISING     = 2'd2,
        ICR_FALLING    = 2'd3
    } t_icr_code;

    // One request as held in the input register.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [2:0]        reg_index;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] pad_levels;
    } t_req;

    // One result word as held in the output register.
    typedef struct packed {
        logic              irq_high_pins;
        logic              irq_low_pins;
        logic [WORD_W-1:0] output_enable;
        logic [WORD_W-1:0] pad_drive;
        logic [WORD_W-1:0] read_data;
    } t_result;

endpackage

>>> rtl/gpio_port_with_pin_interrupts_top.sv
// ============================================================================
// gpio_port_with_pin_interrupts_top: 32-pin GPIO port with pin interrupts
// Each input word is one bus read, one bus write or one pad sample tick.
// The port keeps output data, direction, two interrupt configuration words
// (two bits per pin: low level, high level, rising edge, falling edge), an
// any-edge select that overrides them, an interrupt mask and a
// write-one-to-clear status register. A sample tick sets the status bit of
// every pin that meets its condition, with edges taken against the pads of
// the previous tick (all low after reset). Every input word yields exactly
// one result word that shows the state after the request: the read data
// (zero unless the word was a read), the driven data, the direction and
// two interrupt lines, one for unmasked pending pins 0 to 15 and one for
// pins 16 to 31. Reading the data register returns the pad levels of the
// same word for input pins. The port takes one word per clock while the
// downstream side takes every result: a word is held in the input
// register, then the register file executes it in a single pass and the
// result lands in the output register, from which it leaves; both
// registers keep flowing as long as the downstream side takes every result.
// ============================================================================
module gpio_port_with_pin_interrupts_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: write_data [31:0], pad_levels [63:32]
    input  logic [63:0]  i_s_tdata,
    // tuser: req_type [1:0], reg_index [4:2]
    input  logic [4:0]   i_s_tuser,
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: read_data [31:0], pad_drive [63:32], output_enable [95:64],
    //        irq_low_pins [96], irq_high_pins [97], zero fill [103:98]
    output logic [103:0] o_m_tdata
);

    localparam int RES_W = $bits(gpio_pkg::t_result);

    logic              r_in_valid;
    gpio_pkg::t_req    r_in_req;
    logic              r_out_valid;
    gpio_pkg::t_result r_out_res;

    gpio_pkg::t_result step_res;
    logic              out_free;
    logic              step;

    // The output register can take a new result when it is empty or when
    // its current result leaves in this cycle.
    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req.req_type   <= i_s_tuser[1:0];
            r_in_req.reg_index  <= i_s_tuser[4:2];
            r_in_req.write_data <= i_s_tdata[31:0];
            r_in_req.pad_levels <= i_s_tdata[63:32];
        end
    end

    gpio_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_req    (r_in_req),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(104 - RES_W){1'b0}}, r_out_res};

endmodule

>>> rtl/gpio_irq_detect.sv
// ============================================================================
// gpio_irq_detect: per-pin interrupt condition check
// Compares the sampled pad levels against the previous sample and the
// configured condition of each pin and flags the pins that hit.
// ============================================================================
module gpio_irq_detect (
    input  logic [gpio_pkg::WORD_W-1:0] i_pads,
    input  logic [gpio_pkg::WORD_W-1:0] i_prev_pads,
    input  logic [gpio_pkg::WORD_W-1:0] i_icr_low,
    input  logic [gpio_pkg::WORD_W-1:0] i_icr_high,
    input  logic [gpio_pkg::WORD_W-1:0] i_any_edge,
    output logic [gpio_pkg::WORD_W-1:0] o_hits
);

    for (genvar p = 0; p < gpio_pkg::WORD_W; p++) begin : g_pin
        if (p < gpio_pkg::PIN_COUNT) begin : g_live
            logic [1:0] code;
            logic       now_lvl;
            logic       was_lvl;
            logic       pin_hit;

            // Pins of the low half read the low word, the rest the high word.
            if (p < gpio_pkg::HALF_PINS) begin : g_lo
                assign code = i_icr_low[2*p +: 2];
            end else begin : g_hi
                assign code = i_icr_high[2*(p-gpio_pkg::HALF_PINS) +: 2];
            end

            assign now_lvl = i_pads[p];
            assign was_lvl = i_prev_pads[p];

            always_comb begin
                if (i_any_edge[p]) begin
                    pin_hit = now_lvl ^ was_lvl;
                end else begin
                    case (gpio_pkg::t_icr_code'(code))
                        gpio_pkg::ICR_LOW_LEVEL:  pin_hit = ~now_lvl;
                        gpio_pkg::ICR_HIGH_LEVEL: pin_hit = now_lvl;
                        gpio_pkg::ICR_RISING:     pin_hit = ~was_lvl & now_lvl;
                        gpio_pkg::ICR_FALLING:    pin_hit = was_lvl & ~now_lvl;
                        default:                  pin_hit = 1'b0;
                    endcase
                end
            end

            assign o_hits[p] = pin_hit;
        end else begin : g_absent
            assign o_hits[p] = 1'b0;
        end
    end

endmodule

>>> rtl/gpio_regs.sv
// ============================================================================
// gpio_regs: GPIO register file and request execution
// Holds the port state, applies one read, write or sample tick per step and
// forms the result word from the state after the step.
// ============================================================================
module gpio_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  gpio_pkg::t_req     i_req,
    output gpio_pkg::t_result  o_result
);

    logic [gpio_pkg::WORD_W-1:0] r_data_out, n_data_out;
    logic [gpio_pkg::WORD_W-1:0] r_direction, n_direction;
    logic [gpio_pkg::WORD_W-1:0] r_icr_low, n_icr_low;
    logic [gpio_pkg::WORD_W-1:0] r_icr_high, n_icr_high;
    logic [gpio_pkg::WORD_W-1:0] r_int_mask, n_int_mask;
    logic [gpio_pkg::WORD_W-1:0] r_int_status, n_int_status;
    logic [gpio_pkg::WORD_W-1:0] r_any_edge, n_any_edge;
    logic [gpio_pkg::WORD_W-1:0] r_prev_pads, n_prev_pads;

    logic [gpio_pkg::WORD_W-1:0] hits;
    logic [gpio_pkg::WORD_W-1:0] rd_data;
    logic [gpio_pkg::WORD_W-1:0] pending;
    logic [gpio_pkg::WORD_W-1:0] wd;

    assign wd = i_req.write_data;

    gpio_irq_detect u_detect (
        .i_pads      (i_req.pad_levels),
        .i_prev_pads (r_prev_pads),
        .i_icr_low   (r_icr_low),
        .i_icr_high  (r_icr_high),
        .i_any_edge  (r_any_edge),
        .o_hits      (hits)
    );

    // Next state of every register for the request in hand.
    always_comb begin
        n_data_out   = r_data_out;
        n_direction  = r_direction;
        n_icr_low    = r_icr_low;
        n_icr_high   = r_icr_high;
        n_int_mask   = r_int_mask;
        n_int_status = r_int_status;
        n_any_edge   = r_any_edge;
        n_prev_pads  = r_prev_pads;
        rd_data      = '0;
        case (gpio_pkg::t_req_type'(i_req.req_type))
            gpio_pkg::REQ_READ: begin
                case (gpio_pkg::t_reg_idx'(i_req.reg_index))
                    gpio_pkg::REG_DATA: rd_data = (r_data_out & r_direction)
                        | (i_req.pad_levels & ~r_direction & gpio_pkg::PIN_MASK);
                    gpio_pkg::REG_DIR:      rd_data = r_direction;
                    gpio_pkg::REG_ICR_LOW:  rd_data = r_icr_low;
                    gpio_pkg::REG_ICR_HIGH: rd_data = r_icr_high;
                    gpio_pkg::REG_MASK:     rd_data = r_int_mask;
                    gpio_pkg::REG_STATUS:   rd_data = r_int_status;
                    gpio_pkg::REG_EDGE_SEL: rd_data = r_any_edge;
                    default:                rd_data = '0;
                endcase
            end
            gpio_pkg::REQ_WRITE: begin
                case (gpio_pkg::t_reg_idx'(i_req.reg_index))
                    gpio_pkg::REG_DATA:     n_data_out   = wd & gpio_pkg::PIN_MASK;
                    gpio_pkg::REG_DIR:      n_direction  = wd & gpio_pkg::PIN_MASK;
                    gpio_pkg::REG_ICR_LOW:  n_icr_low    = wd;
                    gpio_pkg::REG_ICR_HIGH: n_icr_high   = wd;
                    gpio_pkg::REG_MASK:     n_int_mask   = wd & gpio_pkg::PIN_MASK;
                    gpio_pkg::REG_STATUS:   n_int_status = r_int_status & ~wd;
                    gpio_pkg::REG_EDGE_SEL: n_any_edge   = wd & gpio_pkg::PIN_MASK;
                    default:                n_data_out   = r_data_out;
                endcase
            end
            gpio_pkg::REQ_SAMPLE: begin
                n_int_status = r_int_status | (hits & gpio_pkg::PIN_MASK);
                n_prev_pads  = i_req.pad_levels & gpio_pkg::PIN_MASK;
            end
            default: rd_data = '0;
        endcase
    end

    assign pending = n_int_status & n_int_mask;

    always_comb begin
        o_result.read_data     = rd_data;
        o_result.pad_drive     = n_data_out;
        o_result.output_enable = n_direction;
        o_result.irq_low_pins  = |pending[gpio_pkg::HALF_PINS-1:0];
        o_result.irq_high_pins = |pending[gpio_pkg::WORD_W-1:gpio_pkg::HALF_PINS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_out   <= '0;
            r_direction  <= '0;
            r_icr_low    <= '0;
            r_icr_high   <= '0;
            r_int_mask   <= '0;
            r_int_status <= '0;
            r_any_edge   <= '0;
            r_prev_pads  <= '0;
        end else if (i_step) begin
            r_data_out   <= n_data_out;
            r_direction  <= n_direction;
            r_icr_low    <= n_icr_low;
            r_icr_high   <= n_icr_high;
            r_int_mask   <= n_int_mask;
            r_int_status <= n_int_status;
            r_any_edge   <= n_any_edge;
            r_prev_pads  <= n_prev_pads;
        end
    end

endmodule
